// ----- hdl/hcbp_pkg.sv -----
// Package for the Huffman code bit packer: widths, command codes and
// the control struct shared between the top level and the packer stage.
// No dependencies.
package hcbp_pkg;

  // Fixed field widths
  localparam int WORD_BITS        = 32;
  localparam int CODE_BITS        = 24;
  localparam int LEN_BITS         = 5;
  localparam int ENTRY_BITS       = CODE_BITS + LEN_BITS;
  localparam int TABLE_DEPTH      = 256;
  localparam int SYM_BITS         = 8;
  localparam int USED_BITS        = 5;
  localparam int SUM_BITS         = USED_BITS + 1;
  localparam int MAX_CODE_LEN_DEF = 24;

  // Command codes carried in tuser
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_ENCODE = 2'd1;
  localparam logic [1:0] CMD_FLUSH  = 2'd2;

  // Item held in the lookup stage while its table entry is read
  typedef struct packed {
    logic       vld;
    logic [1:0] cmd;
  } stage_t;

endpackage

// ----- hdl/hcbp_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. Depends on nothing.
module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/hcbp_packer.sv -----
// Packer stage: appends the looked-up code to the pending word, emits full
// and flushed words through an output register. Depends on hcbp_pkg.
module hcbp_packer
  import hcbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  stage_t                stage,
  input  logic [ENTRY_BITS-1:0] entry,
  output logic                  adv,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [WORD_BITS-1:0]  out_word,
  output logic                  out_last
);

  logic [WORD_BITS-1:0] pending_r, pending_nxt;
  logic [USED_BITS-1:0] used_r, used_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic [WORD_BITS-1:0] out_word_r, out_word_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [LEN_BITS-1:0]    len;
  logic [CODE_BITS-1:0]   code;
  logic [CODE_BITS-1:0]   code_top;
  logic [2*WORD_BITS-1:0] ext;
  logic [2*WORD_BITS-1:0] joined;
  logic [SUM_BITS-1:0]    sum;
  logic                   emit;

  // Stage moves on when the output register is free or being drained
  assign adv = !out_vld_r || out_tready;

  // Keep only the top len bits of the code, align to the free position
  assign len      = entry[ENTRY_BITS-1 -: LEN_BITS];
  assign code     = entry[CODE_BITS-1:0];
  assign code_top = code & ~({CODE_BITS{1'b1}} >> len);
  assign ext      = {code_top, {(2*WORD_BITS-CODE_BITS){1'b0}}} >> used_r;
  assign joined   = {pending_r, {WORD_BITS{1'b0}}} | ext;
  assign sum      = SUM_BITS'(used_r) + SUM_BITS'(len);

  // Next state of the pending word and output register
  always_comb begin
    pending_nxt  = pending_r;
    used_nxt     = used_r;
    emit         = 1'b0;
    out_word_nxt = out_word_r;
    out_last_nxt = out_last_r;
    if (stage.vld && adv) begin
      unique case (stage.cmd)
        CMD_ENCODE: begin
          if (len != '0) begin
            if (sum >= SUM_BITS'(WORD_BITS)) begin
              emit         = 1'b1;
              out_word_nxt = joined[2*WORD_BITS-1:WORD_BITS];
              out_last_nxt = 1'b0;
              pending_nxt  = joined[WORD_BITS-1:0];
              used_nxt     = USED_BITS'(sum - SUM_BITS'(WORD_BITS));
            end else begin
              pending_nxt  = joined[2*WORD_BITS-1:WORD_BITS];
              used_nxt     = USED_BITS'(sum);
            end
          end
        end
        CMD_FLUSH: begin
          emit         = 1'b1;
          out_word_nxt = pending_r;
          out_last_nxt = 1'b1;
          pending_nxt  = '0;
          used_nxt     = '0;
        end
        default: begin
          // load and unknown commands leave the packer alone
        end
      endcase
    end
    if (emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      used_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      pending_r <= pending_nxt;
      used_r    <= used_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_word   = out_word_r;
  assign out_last   = out_last_r;

endmodule

// ----- hdl/huffman_code_bit_packer_top.sv -----
// Top level of the Huffman code bit packer: code table RAM, lookup stage
// and packer stage. Depends on hcbp_pkg, hcbp_ram and hcbp_packer.
//
// Takes one item per clock, loads, encodes and flushes alike, with no
// bubbles while the output side keeps up. An encode enters the lookup
// stage on the same edge that reads its code table entry (synchronous
// RAM). When the item leaves the lookup stage, the packer appends the code
// and, when a word completes, loads it into the output register, which
// drives out_tvalid. While a word waits in the output register with
// out_tready low, the lookup stage holds and, if it holds an item,
// in_tready drops. The table is written on the accept edge of a load, so
// an encode of the same symbol may follow in the very next cycle. Entries
// never loaded read as garbage; there is no clearing pass. A flush always
// sends one word with tlast set, zero padded.
module huffman_code_bit_packer_top
  import hcbp_pkg::*;
#(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] symbol, [39:8] table_word
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] packed_word
  output logic        out_tlast
);

  stage_t                 stage_r, stage_nxt;
  logic                   accept;
  logic                   adv;
  logic [SYM_BITS-1:0]    sym;
  logic [WORD_BITS-1:0]   tw;
  logic [LEN_BITS-1:0]    sat_len;
  logic [ENTRY_BITS-1:0]  wr_entry;
  logic [ENTRY_BITS-1:0]  rd_entry;
  logic                   tbl_we;
  logic                   tbl_re;

  assign sym = in_tdata[SYM_BITS-1:0];
  assign tw  = in_tdata[SYM_BITS +: WORD_BITS];

  // Handshake: take an item whenever the lookup stage is empty or moving
  assign in_tready = !stage_r.vld || adv;
  assign accept    = in_tvalid && in_tready;

  // Saturate the length on load
  assign sat_len  = (tw[7:0] > 8'(MAX_CODE_LEN)) ? LEN_BITS'(MAX_CODE_LEN)
                                                 : tw[LEN_BITS-1:0];
  assign wr_entry = {sat_len, tw[WORD_BITS-1 -: CODE_BITS]};
  assign tbl_we   = accept && (in_tuser == CMD_LOAD);
  assign tbl_re   = accept && (in_tuser == CMD_ENCODE);

  hcbp_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (sym),
    .wdata (wr_entry),
    .re    (tbl_re),
    .raddr (sym),
    .rdata (rd_entry)
  );

  // Lookup stage register
  always_comb begin
    stage_nxt = stage_r;
    if (accept) begin
      stage_nxt.vld = 1'b1;
      stage_nxt.cmd = in_tuser;
    end else if (adv) begin
      stage_nxt.vld = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
    end else begin
      stage_r <= stage_nxt;
    end
  end

  hcbp_packer u_packer (
    .clk        (clk),
    .rst_n      (rst_n),
    .stage      (stage_r),
    .entry      (rd_entry),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_word   (out_tdata),
    .out_last   (out_tlast)
  );

  // An item never lands on a stalled lookup stage
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (!stage_r.vld || adv))
    else $error("item accepted over a stalled lookup stage");

  // A flush leaving the lookup stage shows up as a final word
  a_flush_word: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_r.vld && adv && (stage_r.cmd == CMD_FLUSH)) |=> (out_tvalid && out_tlast))
    else $error("flush did not produce a final word");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && !stage_r.vld))
    else $error("pipeline not empty after reset");

endmodule
